// ===== hw/rtl/b58_pkg.sv =====
`default_nettype none

package b58_pkg;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned PROD_W     = VALUE_W + 6;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned BYTE_IDX_W = 3;

    localparam logic [COUNT_W-1:0] FULL_BLOCK_CHARS = 4'd11;
    localparam logic [COUNT_W-1:0] FULL_BLOCK_BYTES = 4'd8;
    localparam logic [PROD_W-1:0]  RADIX            = 70'd58;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW   = 2'd2;
    localparam logic [1:0] ST_BAD_LENGTH = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       final_flag;
        logic [1:0] status;
    } t_out_item;

    // one item's worth of results, handed from the accumulator to the serializer
    typedef struct packed {
        logic               emit;
        logic               stat_only;
        logic               final_flag;
        logic [1:0]         status;
        logic [COUNT_W-1:0] nbytes;
        logic [VALUE_W-1:0] value;
    } t_burst;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } t_digit;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
    } t_part;

    function automatic t_digit char_digit(input logic [7:0] c);
        t_digit r;
        begin
            r.ok    = 1'b1;
            r.value = 6'd0;
            if (c inside {[8'h31:8'h39]}) begin
                r.value = 6'(c - 8'h31);
            end else if (c inside {[8'h41:8'h48]}) begin
                r.value = 6'(c - 8'h41 + 8'd9);
            end else if (c inside {[8'h4A:8'h4E]}) begin
                r.value = 6'(c - 8'h4A + 8'd17);
            end else if (c inside {[8'h50:8'h5A]}) begin
                r.value = 6'(c - 8'h50 + 8'd22);
            end else if (c inside {[8'h61:8'h6B]}) begin
                r.value = 6'(c - 8'h61 + 8'd33);
            end else if (c inside {[8'h6D:8'h7A]}) begin
                r.value = 6'(c - 8'h6D + 8'd44);
            end else begin
                r.ok = 1'b0;
            end
            return r;
        end
    endfunction

    // bytes carried by a final partial block of n characters
    function automatic t_part partial_bytes(input logic [COUNT_W-1:0] n);
        t_part r;
        begin
            r.ok = 1'b1;
            case (n)
                4'd2:    r.count = 4'd1;
                4'd3:    r.count = 4'd2;
                4'd5:    r.count = 4'd3;
                4'd6:    r.count = 4'd4;
                4'd7:    r.count = 4'd5;
                4'd9:    r.count = 4'd6;
                4'd10:   r.count = 4'd7;
                default: begin
                    r.ok    = 1'b0;
                    r.count = 4'd0;
                end
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/base58_block_decoder.sv =====
// Block base58 decoder: one address character in, decoded bytes out.
// Input channel (i_valid / o_stall / i_in): one character per item, with
// end_of_text set on the last character of an address.
// Output channel (o_valid / i_stall / o_out): one decoded byte per item,
// most significant first; eight per eleven-character block, 1 to 7 for a
// final partial block. An address in error ends with one status-only item.
// The last item of an address has final_flag set and carries the status.
// A character's output passes through the input register, then the 64-bit
// multiply-add into the output register. Characters that yield no output
// are taken one per cycle, even while a burst drains. A character that
// yields output waits in the input register until the last item of the
// current burst is taken. While the receiver stalls, the current output
// item holds and input stops once such a character waits.
// Synchronous reset clears the block value, character count and sticky
// error, and drops any pending item.
`default_nettype none

module base58_block_decoder (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire b58_pkg::t_in_item i_in,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output b58_pkg::t_out_item     o_out
);

    logic              r_in_valid;
    b58_pkg::t_in_item r_in;
    logic              take;
    logic              load;
    logic              slot_free;
    b58_pkg::t_burst   burst;

    assign o_stall = r_in_valid && !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_in;
        end
    end

    b58_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_item      (r_in),
        .i_slot_free (slot_free),
        .o_take      (take),
        .o_load      (load),
        .o_burst     (burst)
    );

    b58_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_burst     (burst),
        .o_slot_free (slot_free),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_out)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/b58_accum.sv =====
`default_nettype none

module b58_accum (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire b58_pkg::t_in_item i_item,
    input  wire logic             i_slot_free,
    output logic                  o_take,
    output logic                  o_load,
    output b58_pkg::t_burst       o_burst
);

    logic [b58_pkg::VALUE_W-1:0] r_value, n_value;
    logic [b58_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]                  r_err, n_err;

    b58_pkg::t_digit              dig;
    b58_pkg::t_part               part;
    logic [b58_pkg::PROD_W-1:0]   prod;
    logic                         last;

    always_comb begin
        last    = i_item.end_of_text;
        dig     = b58_pkg::char_digit(i_item.char_code);
        part    = b58_pkg::partial_bytes(4'd0);
        prod    = ({6'd0, r_value} * b58_pkg::RADIX) + {64'd0, dig.value};
        n_value = r_value;
        n_cnt   = r_cnt;
        n_err   = r_err;
        o_burst = '0;
        if (r_err == b58_pkg::ST_OK) begin
            if (!dig.ok) begin
                n_err = b58_pkg::ST_BAD_CHAR;
            end else if (prod[b58_pkg::PROD_W-1:b58_pkg::VALUE_W] != 6'd0) begin
                n_err = b58_pkg::ST_OVERFLOW;
            end else begin
                n_value = prod[b58_pkg::VALUE_W-1:0];
                n_cnt   = r_cnt + 4'd1;
                if (n_cnt == b58_pkg::FULL_BLOCK_CHARS) begin
                    o_burst.emit       = 1'b1;
                    o_burst.value      = prod[b58_pkg::VALUE_W-1:0];
                    o_burst.nbytes     = b58_pkg::FULL_BLOCK_BYTES;
                    o_burst.final_flag = last;
                    n_value            = '0;
                    n_cnt              = '0;
                end else if (last) begin
                    part = b58_pkg::partial_bytes(n_cnt);
                    if (!part.ok) begin
                        n_err = b58_pkg::ST_BAD_LENGTH;
                    end else begin
                        o_burst.emit       = 1'b1;
                        o_burst.value      = prod[b58_pkg::VALUE_W-1:0];
                        o_burst.nbytes     = part.count;
                        o_burst.final_flag = 1'b1;
                    end
                end
            end
        end
        if (last) begin
            // report the sticky error in place of any bytes
            if (n_err != b58_pkg::ST_OK) begin
                o_burst            = '0;
                o_burst.emit       = 1'b1;
                o_burst.stat_only  = 1'b1;
                o_burst.final_flag = 1'b1;
                o_burst.status     = n_err;
            end
            n_value = '0;
            n_cnt   = '0;
            n_err   = b58_pkg::ST_OK;
        end
        o_take = i_valid && (!o_burst.emit || i_slot_free);
        o_load = o_take && o_burst.emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_cnt   <= '0;
            r_err   <= b58_pkg::ST_OK;
        end else if (o_take) begin
            r_value <= n_value;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < b58_pkg::FULL_BLOCK_CHARS)
        else $error("block character count out of range");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_item.end_of_text |=>
            r_cnt == '0 && r_err == b58_pkg::ST_OK && r_value == '0)
        else $error("state not cleared after last character");

endmodule

`default_nettype wire

// ===== hw/rtl/b58_serializer.sv =====
`default_nettype none

module b58_serializer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire b58_pkg::t_burst  i_burst,
    output logic                  o_slot_free,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output b58_pkg::t_out_item    o_item
);

    logic                                r_busy;
    logic [b58_pkg::BYTE_IDX_W-1:0]      r_idx;
    logic [b58_pkg::VALUE_W-1:0]         r_value;
    logic                                r_stat_only;
    logic                                r_final;
    logic [1:0]                          r_status;
    logic                                done;

    always_comb begin
        done        = r_busy && !i_stall && (r_idx == '0);
        o_slot_free = !r_busy || done;
        o_valid     = r_busy;
        o_item.out_byte   = r_stat_only ? 8'd0 : r_value[{r_idx, 3'b000} +: 8];
        o_item.byte_valid = !r_stat_only;
        o_item.final_flag = r_final && (r_idx == '0);
        o_item.status     = (r_final && (r_idx == '0)) ? r_status : b58_pkg::ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load && o_slot_free) begin
            r_busy <= 1'b1;
            r_idx  <= i_burst.stat_only ? '0 : 3'(i_burst.nbytes - 4'd1);
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (r_busy && !i_stall) begin
            r_idx <= r_idx - 3'd1;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load && o_slot_free) begin
            r_value     <= i_burst.value;
            r_stat_only <= i_burst.stat_only;
            r_final     <= i_burst.final_flag;
            r_status    <= i_burst.status;
        end
    end

    a_hold_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !done |=> r_busy && $stable(r_value) && $stable(r_final))
        else $error("burst overwritten before its last item went out");

    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (!o_item.byte_valid || o_item.status != b58_pkg::ST_OK)
            |-> o_item.final_flag)
        else $error("status item without final flag");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_slot_free)
        else $error("burst offered while output busy");

endmodule

`default_nettype wire

// ===== tb/tb_base58_block_decoder.sv =====
`timescale 1ns / 1ps

module tb_base58_block_decoder;

    localparam logic [8*58-1:0] ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    localparam int unsigned CHAR_TARGET = 300;
    localparam int unsigned LONG_HOLD   = 300;

    typedef struct packed {
        b58_pkg::t_in_item  item;
        logic               typed;
        b58_pkg::t_out_item want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    b58_pkg::t_in_item  i_in    = '0;
    logic               o_stall;
    logic               o_valid;
    b58_pkg::t_out_item o_out;

    // decoder state as seen by the predictor
    logic [b58_pkg::VALUE_W-1:0] acc_value = '0;
    logic [b58_pkg::COUNT_W-1:0] acc_count = '0;
    logic [1:0]                  acc_err   = b58_pkg::ST_OK;

    b58_pkg::t_out_item char_out[$];
    b58_pkg::t_out_item pending_out[$];
    t_row               script[$];
    int unsigned tx_calm = 0;
    int unsigned fails = 0;
    int unsigned chars_sent = 0;
    int unsigned live_chars = 0;
    int unsigned addresses = 0;
    int unsigned bytes_checked = 0;
    int unsigned final_seen[4] = '{0, 0, 0, 0};

    base58_block_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("base58_block_decoder: mismatch");
        $finish;
    end

    function automatic logic [7:0] symbol(input int unsigned idx);
        return ALPHABET[8*(57-idx) +: 8];
    endfunction

    function automatic int alpha_digit(input logic [7:0] c);
        for (int i = 0; i < 58; i++) begin
            if (symbol(i) == c) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic b58_pkg::t_out_item status_item(input logic [1:0] st);
        b58_pkg::t_out_item r;
        r.out_byte   = 8'h00;
        r.byte_valid = 1'b0;
        r.final_flag = 1'b1;
        r.status     = st;
        return r;
    endfunction

    // low n bytes of v, most significant first
    function automatic void emit_bytes(input logic [b58_pkg::VALUE_W-1:0] v, input int n,
                                       input logic fin);
        b58_pkg::t_out_item r;
        for (int j = n; j > 0; j--) begin
            r.out_byte   = v[8*(j-1) +: 8];
            r.byte_valid = 1'b1;
            r.final_flag = (j == 1) ? fin : 1'b0;
            r.status     = b58_pkg::ST_OK;
            char_out.push_back(r);
        end
    endfunction

    function automatic void decode_char(input b58_pkg::t_in_item it);
        int                         d;
        int                         nb;
        logic [b58_pkg::PROD_W-1:0] wide;
        char_out.delete();
        if (acc_err == b58_pkg::ST_OK) begin
            d = alpha_digit(it.char_code);
            if (d < 0) begin
                acc_err = b58_pkg::ST_BAD_CHAR;
            end else begin
                wide = {6'd0, acc_value} * b58_pkg::RADIX + {64'd0, d[5:0]};
                if (wide[b58_pkg::PROD_W-1:b58_pkg::VALUE_W] != '0) begin
                    acc_err = b58_pkg::ST_OVERFLOW;
                end else begin
                    acc_value = wide[b58_pkg::VALUE_W-1:0];
                    acc_count = acc_count + 1'b1;
                    if (acc_count == b58_pkg::FULL_BLOCK_CHARS) begin
                        emit_bytes(acc_value, int'(b58_pkg::FULL_BLOCK_BYTES),
                                   it.end_of_text);
                        acc_value = '0;
                        acc_count = '0;
                    end else if (it.end_of_text) begin
                        case (acc_count)
                            4'd2:    nb = 1;
                            4'd3:    nb = 2;
                            4'd5:    nb = 3;
                            4'd6:    nb = 4;
                            4'd7:    nb = 5;
                            4'd9:    nb = 6;
                            4'd10:   nb = 7;
                            default: nb = -1;
                        endcase
                        if (nb < 0) begin
                            acc_err = b58_pkg::ST_BAD_LENGTH;
                        end else begin
                            emit_bytes(acc_value, nb, 1'b1);
                        end
                    end
                end
            end
        end
        if (it.end_of_text) begin
            if (acc_err != b58_pkg::ST_OK) begin
                char_out.delete();
                char_out.push_back(status_item(acc_err));
            end
            acc_value = '0;
            acc_count = '0;
            acc_err   = b58_pkg::ST_OK;
        end
    endfunction

    // wait in cycles before the next item; runs of zero give stretches without gaps
    function automatic int unsigned pick_wait(inout int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(15) == 0) begin
            calm = $urandom_range(30, 10);
        end
        return $urandom_range(8);
    endfunction

    task automatic add_row(input logic [7:0] c, input logic eot, input logic typed,
                           input b58_pkg::t_out_item want);
        t_row r;
        r.item.char_code   = c;
        r.item.end_of_text = eot;
        r.typed            = typed;
        r.want             = want;
        script.push_back(r);
    endtask

    task automatic send_char(input b58_pkg::t_in_item it, input logic typed,
                             input b58_pkg::t_out_item want);
        int unsigned gap;
        gap = pick_wait(tx_calm);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= it;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        chars_sent++;
        if (acc_err == b58_pkg::ST_OK) begin
            live_chars++;
        end
        if (it.end_of_text) begin
            addresses++;
        end
        decode_char(it);
        if (typed) begin
            pending_out.push_back(want);
        end else begin
            foreach (char_out[k]) begin
                pending_out.push_back(char_out[k]);
            end
        end
    endtask

    initial begin : in_side
        int unsigned       len;
        b58_pkg::t_in_item it;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes of the byte; bad character stays sticky up to the end marker
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b1, status_item(b58_pkg::ST_BAD_CHAR));
        // one-character address is a bad length
        add_row("1", 1'b1, 1'b1, status_item(b58_pkg::ST_BAD_LENGTH));
        // two characters give one zero byte
        add_row("1", 1'b0, 1'b0, '0);
        add_row("1", 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, b58_pkg::ST_OK});
        // eleven top digits overflow on the end-marked character itself
        for (int k = 0; k < 10; k++) begin
            add_row("z", 1'b0, 1'b0, '0);
        end
        add_row("z", 1'b1, 1'b1, status_item(b58_pkg::ST_OVERFLOW));
        // full block closed by the end marker
        for (int k = 0; k < 10; k++) begin
            add_row("1", 1'b0, 1'b0, '0);
        end
        add_row("z", 1'b1, 1'b0, '0);

        foreach (script[r]) begin
            send_char(script[r].item, script[r].typed, script[r].want);
        end

        // mostly well-formed addresses of random length, with noise bytes and
        // now and then a dropped end marker
        while (chars_sent < CHAR_TARGET) begin
            len = 11 * $urandom_range(2) + $urandom_range(10);
            if (len == 0) begin
                len = 1;
            end
            for (int k = 0; k < len; k++) begin
                it.char_code = symbol($urandom_range(57));
                if ((k % 11) == 0 && $urandom_range(1) == 0) begin
                    // keep the lead digit low so that whole blocks fit
                    it.char_code = symbol($urandom_range(30));
                end
                if ($urandom_range(39) == 0) begin
                    it.char_code = 8'($urandom_range(255));
                end
                it.end_of_text = (k == len - 1) && ($urandom_range(11) != 0);
                send_char(it, 1'b0, '0);
            end
        end
        // close whatever address is still open
        it.char_code   = "2";
        it.end_of_text = 1'b1;
        send_char(it, 1'b0, '0);
        i_valid <= 1'b0;

        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        $display("%0d addresses from %0d characters (%0d decoded, the rest skipped)",
                 addresses, chars_sent, live_chars);
        $display("%0d decoded bytes compared; endings: %0d ok, %0d bad char, %0d overflow, %0d bad length",
                 bytes_checked, final_seen[b58_pkg::ST_OK], final_seen[b58_pkg::ST_BAD_CHAR],
                 final_seen[b58_pkg::ST_OVERFLOW], final_seen[b58_pkg::ST_BAD_LENGTH]);
        if (fails == 0) begin
            $display("base58_block_decoder: match");
        end else begin
            $display("base58_block_decoder: mismatch");
        end
        $finish;
    end

    initial begin : out_side
        b58_pkg::t_out_item want;
        int unsigned        hold;
        int unsigned        calm;
        int unsigned        got;
        calm = 0;
        got  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            // one long hold-off lets the block fill and stall its input
            hold = (got == 40) ? LONG_HOLD : pick_wait(calm);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got++;
            if (pending_out.size() == 0) begin
                $error("output item %h with nothing expected", o_out);
                fails++;
            end else begin
                want = pending_out.pop_front();
                if (want.byte_valid) begin
                    bytes_checked++;
                end
                if (want.final_flag) begin
                    final_seen[want.status]++;
                end
                if (o_out.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, o_out.out_byte);
                    fails++;
                end
                if (o_out.byte_valid !== want.byte_valid) begin
                    $error("byte_valid: expected %b, got %b", want.byte_valid,
                           o_out.byte_valid);
                    fails++;
                end
                if (o_out.final_flag !== want.final_flag) begin
                    $error("final_flag: expected %b, got %b", want.final_flag,
                           o_out.final_flag);
                    fails++;
                end
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out.status);
                    fails++;
                end
            end
        end
    end

endmodule
